// ===== hw/rtl/sha256_pkg.sv =====
// Shared types, state codes and SHA-256 constant tables for the message hasher.
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last_byte;
    } sha256_in_t;

    typedef struct packed {
        logic [63:0] digest_part_0;
        logic [63:0] digest_part_1;
        logic [63:0] digest_part_2;
        logic [63:0] digest_part_3;
    } sha256_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_DONE
    } sha256_state_t;

    // Commands from the sequencer to the round datapath.
    typedef struct packed {
        logic       load;
        logic       round_en;
        logic       add;
        logic       init;
        logic [5:0] rnd;
    } sha256_core_ctrl_t;

    localparam logic [3:0] LAST_WORD = 4'd15;
    localparam logic [3:0] LEN_HI_WORD = 4'd14;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [5:0] LAST_BLOCK_POS = 6'd63;
    localparam logic [7:0] PAD_MARK = 8'h80;

    function automatic logic [31:0] sha256_iv(input logic [2:0] idx);
        logic [31:0] val;
        case (idx)
            3'd0:    val = 32'h6a09e667;
            3'd1:    val = 32'hbb67ae85;
            3'd2:    val = 32'h3c6ef372;
            3'd3:    val = 32'ha54ff53a;
            3'd4:    val = 32'h510e527f;
            3'd5:    val = 32'h9b05688c;
            3'd6:    val = 32'h1f83d9ab;
            3'd7:    val = 32'h5be0cd19;
            default: val = 32'h6a09e667;
        endcase
        return val;
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] idx);
        logic [31:0] val;
        case (idx)
            6'd0:    val = 32'h428a2f98;
            6'd1:    val = 32'h71374491;
            6'd2:    val = 32'hb5c0fbcf;
            6'd3:    val = 32'he9b5dba5;
            6'd4:    val = 32'h3956c25b;
            6'd5:    val = 32'h59f111f1;
            6'd6:    val = 32'h923f82a4;
            6'd7:    val = 32'hab1c5ed5;
            6'd8:    val = 32'hd807aa98;
            6'd9:    val = 32'h12835b01;
            6'd10:   val = 32'h243185be;
            6'd11:   val = 32'h550c7dc3;
            6'd12:   val = 32'h72be5d74;
            6'd13:   val = 32'h80deb1fe;
            6'd14:   val = 32'h9bdc06a7;
            6'd15:   val = 32'hc19bf174;
            6'd16:   val = 32'he49b69c1;
            6'd17:   val = 32'hefbe4786;
            6'd18:   val = 32'h0fc19dc6;
            6'd19:   val = 32'h240ca1cc;
            6'd20:   val = 32'h2de92c6f;
            6'd21:   val = 32'h4a7484aa;
            6'd22:   val = 32'h5cb0a9dc;
            6'd23:   val = 32'h76f988da;
            6'd24:   val = 32'h983e5152;
            6'd25:   val = 32'ha831c66d;
            6'd26:   val = 32'hb00327c8;
            6'd27:   val = 32'hbf597fc7;
            6'd28:   val = 32'hc6e00bf3;
            6'd29:   val = 32'hd5a79147;
            6'd30:   val = 32'h06ca6351;
            6'd31:   val = 32'h14292967;
            6'd32:   val = 32'h27b70a85;
            6'd33:   val = 32'h2e1b2138;
            6'd34:   val = 32'h4d2c6dfc;
            6'd35:   val = 32'h53380d13;
            6'd36:   val = 32'h650a7354;
            6'd37:   val = 32'h766a0abb;
            6'd38:   val = 32'h81c2c92e;
            6'd39:   val = 32'h92722c85;
            6'd40:   val = 32'ha2bfe8a1;
            6'd41:   val = 32'ha81a664b;
            6'd42:   val = 32'hc24b8b70;
            6'd43:   val = 32'hc76c51a3;
            6'd44:   val = 32'hd192e819;
            6'd45:   val = 32'hd6990624;
            6'd46:   val = 32'hf40e3585;
            6'd47:   val = 32'h106aa070;
            6'd48:   val = 32'h19a4c116;
            6'd49:   val = 32'h1e376c08;
            6'd50:   val = 32'h2748774c;
            6'd51:   val = 32'h34b0bcb5;
            6'd52:   val = 32'h391c0cb3;
            6'd53:   val = 32'h4ed8aa4a;
            6'd54:   val = 32'h5b9cca4f;
            6'd55:   val = 32'h682e6ff3;
            6'd56:   val = 32'h748f82ee;
            6'd57:   val = 32'h78a5636f;
            6'd58:   val = 32'h84c87814;
            6'd59:   val = 32'h8cc70208;
            6'd60:   val = 32'h90befffa;
            6'd61:   val = 32'ha4506ceb;
            6'd62:   val = 32'hbef9a3f7;
            6'd63:   val = 32'hc67178f2;
            default: val = 32'h428a2f98;
        endcase
        return val;
    endfunction

endpackage

// ===== hw/rtl/sha256_wmem.sv =====
// Sixteen-word block and message schedule memory, one write and two registered reads.
module sha256_wmem
(
    input  logic        clk,
    input  logic        we,
    input  logic [3:0]  waddr,
    input  logic [31:0] wdata,
    input  logic [3:0]  raddr_a,
    input  logic [3:0]  raddr_b,
    output logic [31:0] rdata_a,
    output logic [31:0] rdata_b
);

    logic [31:0] word_mem [16];
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            word_mem[waddr] <= wdata;
        end
        rd_a_reg <= word_mem[raddr_a];
        rd_b_reg <= word_mem[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

// ===== hw/rtl/sha256_core.sv =====
// SHA-256 round datapath: chaining value, working variables and schedule taps.
module sha256_core import sha256_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  sha256_core_ctrl_t ctrl,
    input  logic [31:0]       word_a,
    input  logic [31:0]       word_b,
    output logic [31:0]       sched_word,
    output logic [255:0]      digest
);

    logic [31:0] chain_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] wm1_reg;
    logic [31:0] wm2_reg;
    logic [31:0] w16_reg;

    logic        early;
    logic [31:0] w_cur;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    // In the first sixteen rounds port A carries the block word itself; later it
    // carries w[t-15] and port B carries w[t-7].
    assign early      = (ctrl.rnd[5:4] == 2'b00);
    assign sched_word = w16_reg + ssig0(word_a) + word_b + ssig1(wm2_reg);
    assign w_cur      = early ? word_a : sched_word;

    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + bsig1(v_reg[4]) + ch + round_const(ctrl.rnd) + w_cur;
    assign t2  = bsig0(v_reg[0]) + maj;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= sha256_iv(3'(i));
            end
        end
        else if (ctrl.init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= sha256_iv(3'(i));
            end
        end
        else if (ctrl.add)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= chain_reg[i] + v_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= chain_reg[i];
            end
        end
        else if (ctrl.round_en)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            wm1_reg  <= w_cur;
            wm2_reg  <= wm1_reg;
            // The word read one round early becomes w[t-16] of the next round.
            w16_reg  <= early ? word_b : word_a;
        end
    end

    assign digest = {chain_reg[0], chain_reg[1], chain_reg[2], chain_reg[3],
                     chain_reg[4], chain_reg[5], chain_reg[6], chain_reg[7]};

endmodule

// ===== hw/rtl/sha256_message_hasher.sv =====
// Top level of the byte-serial SHA-256 hasher: sequencer, padding, byte count and digest output.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+---------------------------------------------
//  in      | request   | in_valid / in_ready  | in_data  : data_byte, byte_present, last_byte
//  out     | result    | out_valid / out_ready| out_data : digest_part_0 .. digest_part_3
//
// A byte request is taken while the sequencer is idle. Every 64th byte starts a
// compression: a load step that reads the first words and loads the working
// variables, 64 rounds at one round per cycle, and an add step that folds them
// into the chaining value. With the single round unit and the block memory, the
// bytes of the next block wait until that compression is done.
// The request marked last adds a padding pass that writes one memory word per
// cycle, from the current word position up to word 15, then one compression;
// when the pad mark falls in the last eight bytes of the block, a second padding
// pass and compression follow. Finally the output register is loaded.
// Reset clears the sequencer, the byte count and the output valid, and returns
// the chaining value to the SHA-256 initial words; the memory needs no clearing.
// The input stalls only while compressing, padding or waiting for the output
// register to free up; a digest waiting to be taken does not stop the next
// message from being absorbed.
module sha256_message_hasher import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  sha256_in_t  in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output sha256_out_t out_data
);

    sha256_state_t     state_reg;
    sha256_state_t     state_next;
    logic [60:0]       count_reg;
    logic [60:0]       count_next;
    logic [31:0]       acc_reg;
    logic [31:0]       acc_next;
    logic [5:0]        rnd_reg;
    logic [5:0]        rnd_next;
    logic [3:0]        widx_reg;
    logic [3:0]        widx_next;
    logic              last_reg;
    logic              last_next;
    logic              padding_reg;
    logic              padding_next;
    logic              second_reg;
    logic              second_next;
    logic              pad_first_reg;
    logic              pad_first_next;
    logic              out_valid_reg;
    sha256_out_t       out_data_reg;

    sha256_core_ctrl_t core_ctrl;
    logic              out_load;
    logic              mem_we;
    logic [3:0]        mem_waddr;
    logic [31:0]       mem_wdata;
    logic [3:0]        raddr_a;
    logic [3:0]        raddr_b;
    logic [31:0]       rdata_a;
    logic [31:0]       rdata_b;
    logic [31:0]       sched_word;
    logic [255:0]      digest;

    logic [60:0]       count_inc;
    logic [1:0]        lane;
    logic [4:0]        lane_shift;
    logic [31:0]       word_base;
    logic [31:0]       byte_word;
    logic [31:0]       pad_word;
    logic [31:0]       len_hi;
    logic [31:0]       len_lo;
    logic              two_blocks;
    logic              len_ok;
    logic [31:0]       pad_value;
    logic [5:0]        rd_round;
    logic              rd_early;

    // Byte packing: lane zero is the most significant byte of the word.
    assign count_inc  = count_reg + 61'd1;
    assign lane       = count_reg[1:0];
    assign lane_shift = {~lane, 3'b000};
    assign word_base  = (lane == 2'b00) ? 32'h0 : acc_reg;
    assign byte_word  = word_base | ({24'h0, in_data.data_byte} << lane_shift);
    assign pad_word   = word_base | ({24'h0, PAD_MARK} << lane_shift);

    // The length field is the byte count times eight, split over words 14 and 15.
    assign len_hi     = count_reg[60:29];
    assign len_lo     = {count_reg[28:0], 3'b000};
    assign two_blocks = (count_reg[5:3] == 3'b111);
    assign len_ok     = !two_blocks || second_reg;

    always_comb
    begin
        if (pad_first_reg)
        begin
            pad_value = pad_word;
        end
        else if (len_ok && (widx_reg == LEN_HI_WORD))
        begin
            pad_value = len_hi;
        end
        else if (len_ok && (widx_reg == LAST_WORD))
        begin
            pad_value = len_lo;
        end
        else
        begin
            pad_value = 32'h0;
        end
    end

    // Reads are issued in the cycle before the round that uses them. Early rounds
    // read w[n] and w[n+1]; later rounds read w[n-15] and w[n-7]. None of these
    // hits the slot that the current round writes back.
    assign rd_round = (state_reg == ST_LOAD) ? 6'd0 : rnd_reg + 6'd1;
    assign rd_early = (rd_round[5:4] == 2'b00);
    assign raddr_a  = rd_early ? rd_round[3:0] : rd_round[3:0] + 4'd1;
    assign raddr_b  = rd_early ? rd_round[3:0] + 4'd1 : rd_round[3:0] + 4'd9;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rnd_reg       <= '0;
            widx_reg      <= '0;
            last_reg      <= 1'b0;
            padding_reg   <= 1'b0;
            second_reg    <= 1'b0;
            pad_first_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rnd_reg       <= rnd_next;
            widx_reg      <= widx_next;
            last_reg      <= last_next;
            padding_reg   <= padding_next;
            second_reg    <= second_next;
            pad_first_reg <= pad_first_next;
            out_valid_reg <= (out_valid_reg && !out_ready) || out_load;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (out_load)
        begin
            out_data_reg <= sha256_out_t'(digest);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        rnd_next       = rnd_reg;
        widx_next      = widx_reg;
        last_next      = last_reg;
        padding_next   = padding_reg;
        second_next    = second_reg;
        pad_first_next = pad_first_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[5:2];
        mem_wdata      = byte_word;
        core_ctrl      = '0;
        core_ctrl.rnd  = rnd_reg;
        in_ready       = 1'b0;
        out_load       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_data.byte_present)
                    begin
                        acc_next   = byte_word;
                        count_next = count_inc;
                        mem_we     = (lane == 2'b11);
                    end
                    if (in_data.byte_present && (count_reg[5:0] == LAST_BLOCK_POS))
                    begin
                        last_next    = in_data.last_byte;
                        padding_next = 1'b0;
                        state_next   = ST_LOAD;
                    end
                    else if (in_data.last_byte)
                    begin
                        last_next      = 1'b1;
                        padding_next   = 1'b1;
                        second_next    = 1'b0;
                        pad_first_next = 1'b1;
                        widx_next      = in_data.byte_present ? count_inc[5:2]
                                                              : count_reg[5:2];
                        state_next     = ST_PAD;
                    end
                end
            end

            ST_LOAD:
            begin
                core_ctrl.load = 1'b1;
                rnd_next       = 6'd0;
                state_next     = ST_ROUND;
            end

            ST_ROUND:
            begin
                core_ctrl.round_en = 1'b1;
                if (rnd_reg[5:4] != 2'b00)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rnd_reg[3:0];
                    mem_wdata = sched_word;
                end
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = ST_ADD;
                end
                else
                begin
                    rnd_next = rnd_reg + 6'd1;
                end
            end

            ST_ADD:
            begin
                core_ctrl.add = 1'b1;
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!padding_reg)
                begin
                    // The last byte closed a block: padding starts a fresh one.
                    padding_next   = 1'b1;
                    second_next    = 1'b0;
                    pad_first_next = 1'b1;
                    widx_next      = count_reg[5:2];
                    state_next     = ST_PAD;
                end
                else if (two_blocks && !second_reg)
                begin
                    second_next    = 1'b1;
                    pad_first_next = 1'b0;
                    widx_next      = 4'd0;
                    state_next     = ST_PAD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_PAD:
            begin
                mem_we         = 1'b1;
                mem_waddr      = widx_reg;
                mem_wdata      = pad_value;
                pad_first_next = 1'b0;
                widx_next      = widx_reg + 4'd1;
                if (widx_reg == LAST_WORD)
                begin
                    state_next = ST_LOAD;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    core_ctrl.init = 1'b1;
                    count_next     = '0;
                    last_next      = 1'b0;
                    padding_next   = 1'b0;
                    second_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    sha256_wmem u_wmem
    (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    sha256_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (core_ctrl),
        .word_a     (rdata_a),
        .word_b     (rdata_b),
        .sched_word (sched_word),
        .digest     (digest)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/sha256_checker.sv =====
// Port-level checks for the SHA-256 message hasher and the bind that attaches them.
module sha256_checker import sha256_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input sha256_in_t  in_data,
    input logic        out_valid,
    input logic        out_ready,
    input sha256_out_t out_data
);

    logic [1:0] pend_reg;
    logic       last_acc;
    logic       out_acc;

    assign last_acc = in_valid && in_ready && in_data.last_byte;
    assign out_acc  = out_valid && out_ready;

    // Counts final requests taken whose digest has not been delivered yet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, last_acc} - {1'b0, out_acc};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("digest dropped or changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
    else $error("digest shown without a final request");

    assert property (@(posedge clk) disable iff (!rst_n)
        last_acc |=> !in_ready)
    else $error("request taken during padding");

    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
    else $error("more digests pending than the output can hold");

endmodule

bind sha256_message_hasher sha256_checker u_sha256_checker (.*);

// ===== dv/sha256_message_hasher_test.sv =====
// Self-checking testbench for the byte-serial SHA-256 message hasher.
`timescale 1ns / 100ps

module sha256_message_hasher_test;
    import sha256_pkg::*;

    // SHA-256 round constants, round 0 in the most significant word.
    localparam logic [2047:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Initial hash words H0..H7, H0 in the most significant word.
    localparam logic [255:0] INITIAL_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int PAD_TWO_BLOCKS_AT = 56;   // byte position from which padding needs two blocks
    localparam int RX_HOLD_CYCLES = 800;     // long receiver stall used to back up the block
    localparam int SETTLE_CYCLES = 400;      // covers padding plus two compressions
    localparam int MAX_REPORTS = 10;

    // Scoreboard: runs its own SHA-256 over every accepted request and keeps
    // the digests that the block still owes, oldest first.
    class digest_scoreboard;
        logic [255:0] digests_due[$];
        bit [31:0] chain[8];
        bit [31:0] window[16];
        bit [60:0] byte_count;
        int failures;

        function new();
            failures = 0;
            foreach (window[i]) window[i] = '0;
            restart();
        endfunction

        // Back to the initial hash words and an empty message.
        function void restart();
            for (int i = 0; i < 8; i++) chain[i] = INITIAL_HASH[255 - 32 * i -: 32];
            byte_count = '0;
        endfunction

        function int pending();
            return digests_due.size();
        endfunction

        static function bit [31:0] rotr(bit [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        // 64 rounds over the block; the block doubles as the message schedule window.
        function void compress();
            bit [31:0] v[8];
            bit [31:0] w;
            bit [31:0] w15;
            bit [31:0] w2;
            bit [31:0] s0;
            bit [31:0] s1;
            bit [31:0] t1;
            bit [31:0] t2;
            for (int i = 0; i < 8; i++) v[i] = chain[i];
            for (int t = 0; t < 64; t++)
            begin
                if (t < 16)
                begin
                    w = window[t];
                end
                else
                begin
                    w15 = window[(t - 15) & 15];
                    w2 = window[(t - 2) & 15];
                    s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
                    s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
                    w = window[t & 15] + s0 + window[(t - 7) & 15] + s1;
                    window[t & 15] = w;
                end
                t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[2047 - 32 * t -: 32] + w;
                t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
        endfunction

        // Big-endian byte placement; the first byte of a word clears it.
        function void place_byte(int pos, bit [7:0] b);
            int wi;
            int sh;
            wi = pos >> 2;
            sh = (3 - (pos & 3)) * 8;
            if ((pos & 3) == 0) window[wi] = '0;
            window[wi] = window[wi] | (32'(b) << sh);
        endfunction

        function void absorb_request(sha256_in_t req);
            int pos;
            bit [63:0] bit_len;
            if (req.byte_present)
            begin
                pos = int'(byte_count[5:0]);
                place_byte(pos, req.data_byte);
                byte_count = byte_count + 1'b1;
                if (pos == 63) compress();
            end
            if (!req.last_byte) return;
            pos = int'(byte_count[5:0]);
            bit_len = {byte_count, 3'b000};
            place_byte(pos, PAD_BYTE);
            for (int i = pos / 4 + 1; i < 16; i++) window[i] = '0;
            if (pos >= PAD_TWO_BLOCKS_AT)
            begin
                compress();
                foreach (window[i]) window[i] = '0;
            end
            window[14] = bit_len[63:32];
            window[15] = bit_len[31:0];
            compress();
            digests_due.insert(digests_due.size(),
                               {chain[0], chain[1], chain[2], chain[3],
                                chain[4], chain[5], chain[6], chain[7]});
            restart();
        endfunction

        function void check_digest(sha256_out_t got);
            logic [255:0] seen;
            logic [255:0] want;
            seen = got;
            if (digests_due.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS) $display("unexpected digest %h", seen);
                return;
            end
            want = digests_due.pop_front();
            for (int k = 0; k < 4; k++)
            begin
                if (seen[255 - 64 * k -: 64] !== want[255 - 64 * k -: 64])
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("digest_part_%0d mismatch: expected %h, got %h",
                                 k, want[255 - 64 * k -: 64], seen[255 - 64 * k -: 64]);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    sha256_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    sha256_out_t out_data;

    // Idle rates in percent. The sender rate is only read by the stimulus
    // process; the receiver rate is updated at clock edges like any other input.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // Each toggle of hold_req asks the receiver process for one long stall.
    logic hold_req = 1'b0;
    logic hold_seen;
    int hold_left;

    int requests_sent = 0;

    digest_scoreboard expected_digests = new();

    sha256_message_hasher DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    // Hard limit on the run: far beyond the slowest correct run, which
    // includes the long receiver stall and every compression of each message.
    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: random ready at the current idle rate, or a long stall when the
    // stimulus asks for one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_seen <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= RX_HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: both handshakes are sampled at the clock edge. A digest is
    // checked before a request at the same edge is absorbed, although a
    // digest can never depend on a request taken at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready) expected_digests.check_digest(out_data);
            if (in_valid && in_ready) expected_digests.absorb_request(in_data);
        end
    end

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
    endtask

    // Offers one request, after a random gap at the sender idle rate, and
    // returns at the edge where it is accepted. Valid is only lowered in a
    // gap, so back-to-back requests keep it high.
    task automatic send_request(input logic [7:0] data, input logic present, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{data_byte: data, byte_present: present, last_byte: last};
        do @(posedge clk); while (!in_ready);
        requests_sent++;
    endtask

    // One message of random bytes. Now and then an empty request is slipped
    // in, which the block must ignore. Some messages end on a request that
    // carries no byte; an empty message always does.
    task automatic send_message(input int len);
        bit marker_end;
        marker_end = (len == 0) || ($urandom_range(4) == 0);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 4) send_request(8'($urandom), 1'b0, 1'b0);
            send_request(8'($urandom), 1'b1, !marker_end && (i == len - 1));
        end
        if (marker_end) send_request(8'($urandom), 1'b0, 1'b1);
    endtask

    // Mostly short messages so that digests are frequent, with a share of
    // lengths around the padding boundaries (one or two final blocks) and a
    // few lengths of up to 200 bytes, mostly multi-block.
    function automatic int pick_length();
        int boundary;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return $urandom_range(12);
            5, 6:          return $urandom_range(40);
            7, 8:
            begin
                case ($urandom_range(3))
                    0:       boundary = 56;
                    1:       boundary = 64;
                    2:       boundary = 120;
                    default: boundary = 128;
                endcase
                return boundary + int'($urandom_range(1)) - 1;
            end
            default:       return $urandom_range(200);
        endcase
    endfunction

    // Stops offering requests and waits until every digest owed has been taken.
    task automatic wait_for_digests();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_digests.pending() != 0);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Phase one: light sender idling, heavy receiver idling.
        set_idling(12, 75);

        // Directed: the empty message, then an ignored request with every
        // data bit set, then one-byte messages at both data extremes.
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'hff, 1'b0, 1'b0);
        send_request(8'h00, 1'b1, 1'b1);
        send_request(8'hff, 1'b1, 1'b1);
        // "abc" with an ignored request inside, closed by a last request
        // that carries no byte.
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'ha5, 1'b0, 1'b0);
        send_request(8'h63, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);
        // "abc" with the last mark on the final byte.
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        // Alternating bit patterns.
        send_request(8'h55, 1'b1, 1'b0);
        send_request(8'haa, 1'b1, 1'b1);
        // The sender waits here until every digest so far has come back.
        wait_for_digests();

        while (requests_sent < 700) send_message(pick_length());
        wait_for_digests();

        // Phase two: the idle rates swap.
        set_idling(75, 12);
        while (requests_sent < 1400) send_message(pick_length());
        wait_for_digests();

        // Phase three: no idling. First the receiver stalls for a long
        // stretch while short messages keep coming, so one digest sits in the
        // output register, the next message completes behind it and the
        // block has to stall its input.
        set_idling(0, 0);
        hold_req <= ~hold_req;
        for (int m = 0; m < 6; m++) send_message($urandom_range(4, 1));
        wait_for_digests();
        while (requests_sent < 1850) send_message(pick_length());
        wait_for_digests();

        // Let any stray digest show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_digests.failures == 0 && expected_digests.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
